// ----- sv/uvsg_pkg.sv -----
// shared types, constants and helpers of the uv sphere vertex generator
package uvsg_pkg;

	localparam int FRACTION_BITS_DEF = 15;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN = 24;

	localparam int QUOT_W = 32;
	localparam int DIV_STEPS = 4;
	localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
	localparam int REM_W = 9;
	localparam int CQ_W = 32;
	localparam int Z_W = 32;
	localparam int IDX_W = 16;
	localparam int POS_W = 24;
	localparam int NORM_W = 16;
	localparam int STATUS_W = 2;
	localparam int RADIUS_W = 16;
	localparam int SEGS_W = 9;
	localparam int RINGS_W = 8;
	localparam int COORD_W = 8;
	localparam int REG_IDX_W = 2;

	localparam logic signed [CQ_W-1:0] GAIN_Q30 = 32'sd652032874;

	localparam logic [REG_IDX_W-1:0] REG_RADIUS        = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RING_COUNT    = 2'd2;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
	localparam logic [SEGS_W-1:0] SEGMENT_COUNT_RST = 9'd32;
	localparam logic [RINGS_W-1:0] RING_COUNT_RST = 8'd16;

	localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_VERTEX_ONLY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE       = 2'd2;

	localparam logic [Z_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUOT_W-1:0] quot;
	} div_t;

	typedef struct packed {
		logic [CQ_W-1:0] x;
		logic [CQ_W-1:0] y;
		logic [Z_W-1:0] z;
		logic [1:0] quad;
	} cordic_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx_here;
		logic [IDX_W-1:0] idx_below;
		logic [IDX_W-1:0] idx_below_next;
		logic [IDX_W-1:0] idx_here_next;
		logic [STATUS_W-1:0] status;
	} side_t;

	// DIV_STEPS restoring division steps, one quotient bit each
	function automatic div_t div_steps(div_t a, logic [REM_W-1:0] dv);
		logic [REM_W:0] t;
		div_t r;
		r = a;
		for (int k = 0; k < DIV_STEPS; k++) begin
			t = {r.rem, 1'b0};
			if (t >= {1'b0, dv}) begin
				t = t - {1'b0, dv};
				r.rem = t[REM_W-1:0];
				r.quot = {r.quot[QUOT_W-2:0], 1'b1};
			end else begin
				r.rem = t[REM_W-1:0];
				r.quot = {r.quot[QUOT_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	// one rotation-mode iteration
	function automatic cordic_t cordic_step(cordic_t a, int i);
		logic signed [CQ_W-1:0] x;
		logic signed [CQ_W-1:0] y;
		logic signed [CQ_W-1:0] dx;
		logic signed [CQ_W-1:0] dy;
		logic signed [Z_W-1:0] z;
		logic signed [Z_W-1:0] at;
		cordic_t r;
		x = $signed(a.x);
		y = $signed(a.y);
		z = $signed(a.z);
		dx = y >>> i;
		dy = x >>> i;
		at = $signed(ATAN_TURNS[i]);
		if (!z[Z_W-1]) begin
			x = x - dx;
			y = y + dy;
			z = z - at;
		end else begin
			x = x + dx;
			y = y - dy;
			z = z + at;
		end
		r.x = x;
		r.y = y;
		r.z = z;
		r.quad = a.quad;
		return r;
	endfunction

endpackage

// ----- sv/uvsg_if.sv -----
// point and vertex channel interfaces
interface uvsg_point_if;
	logic valid;
	logic ready;
	logic [uvsg_pkg::COORD_W-1:0] ring;
	logic [uvsg_pkg::COORD_W-1:0] segment;
	modport source(output valid, ring, segment, input ready);
	modport sink(input valid, ring, segment, output ready);
endinterface

interface uvsg_vertex_if;
	logic valid;
	logic ready;
	logic signed [uvsg_pkg::POS_W-1:0] pos_x;
	logic signed [uvsg_pkg::POS_W-1:0] pos_y;
	logic signed [uvsg_pkg::POS_W-1:0] pos_z;
	logic signed [uvsg_pkg::NORM_W-1:0] norm_x;
	logic signed [uvsg_pkg::NORM_W-1:0] norm_y;
	logic signed [uvsg_pkg::NORM_W-1:0] norm_z;
	logic [uvsg_pkg::IDX_W-1:0] index_here;
	logic [uvsg_pkg::IDX_W-1:0] index_below;
	logic [uvsg_pkg::IDX_W-1:0] index_below_next;
	logic [uvsg_pkg::IDX_W-1:0] index_here_next;
	logic [uvsg_pkg::STATUS_W-1:0] status;
	modport source(output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, index_here,
		index_below, index_below_next, index_here_next, status, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, index_here,
		index_below, index_below_next, index_here_next, status, output ready);
endinterface

// ----- sv/uv_sphere_vertex_generator_unit.sv -----
// uv sphere vertex generator: one grid point in, position, normal and indices out
// Takes one (ring, segment) transaction per cycle while the pipeline is not stalled and returns
// one vertex transaction per point, in order. An input register feeds the angle dividers, which
// take four quotient bits a stage; each CORDIC iteration is one stage, and quadrant restore,
// products, rounding, radius scaling and saturation follow. A stall on the vertex
// side holds the whole pipeline. Write the registers only while no transaction is in flight.
module uv_sphere_vertex_generator_unit #(
	parameter int FRACTION_BITS = uvsg_pkg::FRACTION_BITS_DEF,
	parameter int CORDIC_STAGES = uvsg_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic write_enable,
	input logic [uvsg_pkg::REG_IDX_W-1:0] reg_index,
	input logic [uvsg_pkg::RADIUS_W-1:0] write_data,
	uvsg_point_if.sink point,
	uvsg_vertex_if.source vertex
);

	localparam int D = uvsg_pkg::DIV_STAGES;
	localparam int C = CORDIC_STAGES;
	localparam int NST = D + C + 6;
	localparam int NSH = 30 - FRACTION_BITS;
	localparam int PSH = 38 - FRACTION_BITS;
	localparam int PROD_W = 2 * uvsg_pkg::CQ_W;
	localparam int SCL_W = uvsg_pkg::RADIUS_W + 1 + uvsg_pkg::CQ_W;
	localparam int SEGS_W = uvsg_pkg::SEGS_W;
	localparam int IDX_W = uvsg_pkg::IDX_W;

	logic [uvsg_pkg::RADIUS_W-1:0] radius_q;
	logic [SEGS_W-1:0] segment_count_q;
	logic [uvsg_pkg::RINGS_W-1:0] ring_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= uvsg_pkg::RADIUS_RST;
			segment_count_q <= uvsg_pkg::SEGMENT_COUNT_RST;
			ring_count_q <= uvsg_pkg::RING_COUNT_RST;
		end else if (write_enable) begin
			unique case (reg_index)
				uvsg_pkg::REG_RADIUS: radius_q <= write_data;
				uvsg_pkg::REG_SEGMENT_COUNT: segment_count_q <= write_data[SEGS_W-1:0];
				uvsg_pkg::REG_RING_COUNT: ring_count_q <= write_data[uvsg_pkg::RINGS_W-1:0];
				default: ;
			endcase
		end
	end

	// effective counts
	logic [SEGS_W-1:0] segs;
	logic [uvsg_pkg::RINGS_W-1:0] rings;
	logic [SEGS_W-1:0] rings2;

	always_comb begin
		if (segment_count_q < SEGS_W'(3)) segs = SEGS_W'(3);
		else if (segment_count_q > SEGS_W'(256)) segs = SEGS_W'(256);
		else segs = segment_count_q;
		rings = (ring_count_q < uvsg_pkg::RINGS_W'(2)) ? uvsg_pkg::RINGS_W'(2) : ring_count_q;
		rings2 = {rings, 1'b0};
	end

	logic en;
	logic valid_s [NST];
	uvsg_pkg::side_t side_s [NST];

	assign en = vertex.ready || !valid_s[NST-1];
	assign point.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NST; k++) valid_s[k] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= point.valid;
			for (int k = 1; k < NST; k++) valid_s[k] <= valid_s[k-1];
		end
	end

	// input stage: range check, indices, divider start
	logic in_range;
	logic [16:0] row_base;
	logic [SEGS_W-1:0] seg_next;
	logic [16:0] sum_here, sum_below, sum_here_next, sum_below_next;
	uvsg_pkg::side_t side_in;
	uvsg_pkg::div_t phi_sd [D+1];
	uvsg_pkg::div_t theta_sd [D+1];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < NST; k++) side_s[k] <= side_s[k-1];
		end
	end

	always_comb begin
		in_range = ({1'b0, point.ring} <= {1'b0, rings}) && ({1'b0, point.segment} < segs);
		row_base = 17'(point.ring) * 17'(segs);
		seg_next = ({1'b0, point.segment} + SEGS_W'(1) == segs) ? '0
			: {1'b0, point.segment} + SEGS_W'(1);
		sum_here = row_base + 17'(point.segment);
		sum_here_next = row_base + 17'(seg_next);
		sum_below = sum_here + 17'(segs);
		sum_below_next = sum_here_next + 17'(segs);
		side_in = '0;
		if (!in_range) begin
			side_in.status = uvsg_pkg::STATUS_RANGE;
		end else begin
			side_in.idx_here = sum_here[IDX_W-1:0];
			side_in.idx_here_next = sum_here_next[IDX_W-1:0];
			if (point.ring == rings) begin
				side_in.status = uvsg_pkg::STATUS_VERTEX_ONLY;
			end else begin
				side_in.status = uvsg_pkg::STATUS_OK;
				side_in.idx_below = sum_below[IDX_W-1:0];
				side_in.idx_below_next = sum_below_next[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_sd[0].rem <= in_range ? uvsg_pkg::REM_W'(point.ring) : '0;
			phi_sd[0].quot <= '0;
			theta_sd[0].rem <= in_range ? uvsg_pkg::REM_W'(point.segment) : '0;
			theta_sd[0].quot <= '0;
		end
	end

	// angle dividers: phi = ring*2^32/(2R), theta = segment*2^32/S
	for (genvar d = 0; d < D; d++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				phi_sd[d+1] <= uvsg_pkg::div_steps(phi_sd[d], rings2);
				theta_sd[d+1] <= uvsg_pkg::div_steps(theta_sd[d], segs);
			end
		end
	end

	// cordic iterations
	uvsg_pkg::cordic_t phi_sc [C+1];
	uvsg_pkg::cordic_t theta_sc [C+1];

	assign phi_sc[0] = '{x: uvsg_pkg::GAIN_Q30, y: '0,
		z: {2'b00, phi_sd[D].quot[29:0]}, quad: phi_sd[D].quot[31:30]};
	assign theta_sc[0] = '{x: uvsg_pkg::GAIN_Q30, y: '0,
		z: {2'b00, theta_sd[D].quot[29:0]}, quad: theta_sd[D].quot[31:30]};

	for (genvar c = 0; c < C; c++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				phi_sc[c+1] <= uvsg_pkg::cordic_step(phi_sc[c], c);
				theta_sc[c+1] <= uvsg_pkg::cordic_step(theta_sc[c], c);
			end
		end
	end

	// quadrant restore
	logic signed [uvsg_pkg::CQ_W-1:0] cp_s2, sp_s2, ct_s2, st_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (phi_sc[C].quad)
				2'd0: begin cp_s2 <= phi_sc[C].x; sp_s2 <= phi_sc[C].y; end
				2'd1: begin cp_s2 <= -$signed(phi_sc[C].y); sp_s2 <= phi_sc[C].x; end
				2'd2: begin cp_s2 <= -$signed(phi_sc[C].x); sp_s2 <= -$signed(phi_sc[C].y); end
				default: begin cp_s2 <= phi_sc[C].y; sp_s2 <= -$signed(phi_sc[C].x); end
			endcase
			unique case (theta_sc[C].quad)
				2'd0: begin ct_s2 <= theta_sc[C].x; st_s2 <= theta_sc[C].y; end
				2'd1: begin ct_s2 <= -$signed(theta_sc[C].y); st_s2 <= theta_sc[C].x; end
				2'd2: begin
					ct_s2 <= -$signed(theta_sc[C].x);
					st_s2 <= -$signed(theta_sc[C].y);
				end
				default: begin ct_s2 <= theta_sc[C].y; st_s2 <= -$signed(theta_sc[C].x); end
			endcase
		end
	end

	// products
	logic signed [PROD_W-1:0] px_s3, pz_s3;
	logic signed [uvsg_pkg::CQ_W-1:0] cp_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= sp_s2 * ct_s2;
			pz_s3 <= sp_s2 * st_s2;
			cp_s3 <= cp_s2;
		end
	end

	// normals in q30
	logic signed [PROD_W-1:0] rx, rz;
	logic signed [uvsg_pkg::CQ_W-1:0] n_s4 [3];

	always_comb begin
		rx = (px_s3 + (PROD_W'(1) <<< 29)) >>> 30;
		rz = (pz_s3 + (PROD_W'(1) <<< 29)) >>> 30;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s4[0] <= rx[uvsg_pkg::CQ_W-1:0];
			n_s4[1] <= cp_s3;
			n_s4[2] <= rz[uvsg_pkg::CQ_W-1:0];
		end
	end

	// radius scaling and normal rounding
	logic signed [SCL_W-1:0] scl_s5 [3];
	logic signed [uvsg_pkg::NORM_W-1:0] norm_s5 [3];
	logic signed [63:0] nr [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nr[k] = (64'(n_s4[k]) + (64'sd1 <<< (NSH - 1))) >>> NSH;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				scl_s5[k] <= $signed({1'b0, radius_q}) * n_s4[k];
				if (nr[k] < -64'sd32768) norm_s5[k] <= -16'sd32768;
				else if (nr[k] > 64'sd32767) norm_s5[k] <= 16'sd32767;
				else norm_s5[k] <= nr[k][uvsg_pkg::NORM_W-1:0];
			end
		end
	end

	// position rounding, saturation, output register
	logic signed [63:0] pr [3];
	logic signed [uvsg_pkg::POS_W-1:0] pos_s6 [3];
	logic signed [uvsg_pkg::NORM_W-1:0] norm_s6 [3];
	logic range_s5;

	assign range_s5 = (side_s[NST-2].status == uvsg_pkg::STATUS_RANGE);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pr[k] = (64'(scl_s5[k]) + (64'sd1 <<< (PSH - 1))) >>> PSH;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (range_s5) pos_s6[k] <= '0;
				else if (pr[k] < -64'sd8388608) pos_s6[k] <= -24'sd8388608;
				else if (pr[k] > 64'sd8388607) pos_s6[k] <= 24'sd8388607;
				else pos_s6[k] <= pr[k][uvsg_pkg::POS_W-1:0];
				norm_s6[k] <= range_s5 ? '0 : norm_s5[k];
			end
		end
	end

	assign vertex.valid = valid_s[NST-1];
	assign vertex.pos_x = pos_s6[0];
	assign vertex.pos_y = pos_s6[1];
	assign vertex.pos_z = pos_s6[2];
	assign vertex.norm_x = norm_s6[0];
	assign vertex.norm_y = norm_s6[1];
	assign vertex.norm_z = norm_s6[2];
	assign vertex.index_here = side_s[NST-1].idx_here;
	assign vertex.index_below = side_s[NST-1].idx_below;
	assign vertex.index_below_next = side_s[NST-1].idx_below_next;
	assign vertex.index_here_next = side_s[NST-1].idx_here_next;
	assign vertex.status = side_s[NST-1].status;

endmodule
